>>> design/ptu_pkg.sv
// package for the pattern track unpacker: cell type, effect codes and translation
// depends on nothing
`timescale 1ns / 1ps
package ptu_pkg;

   localparam int MaxRowsDefault = 256;
   localparam logic [8:0] RowCountReset = 9'd64;

   typedef enum logic [4:0] {
      FX_NONE = 5'd0, FX_PORTA_UP = 5'd1, FX_PORTA_DOWN = 5'd2, FX_TONE_PORTA = 5'd3,
      FX_VIBRATO = 5'd4, FX_ARPEGGIO = 5'd5, FX_SPEED = 5'd6, FX_TEMPO = 5'd7,
      FX_PAN = 5'd8, FX_JUMP = 5'd9, FX_GLOBAL_VOL = 5'd10, FX_BREAK = 5'd11,
      FX_EXTENDED = 5'd12, FX_PAN_SLIDE = 5'd13, FX_RETRIG = 5'd14,
      FX_GVOL_SLIDE = 5'd15, FX_VOL_SLIDE = 5'd16, FX_TREMOLO = 5'd17,
      FX_TREMOR = 5'd18, FX_OFFSET = 5'd19
   } effect_type;

   typedef enum logic [1:0] {
      HDR_SKIP = 2'd0, HDR_REPEAT = 2'd1, HDR_COPY = 2'd2, HDR_GATHER = 2'd3
   } header_type;

   typedef struct packed {
      logic [7:0] note;
      logic [7:0] instrument;
      logic       has_volume;
      logic [6:0] volume;
      logic [4:0] effect;
      logic [7:0] effect_param;
   } cell_type;

   typedef struct packed {
      logic [4:0] effect;
      logic [7:0] param;
      logic       valid;
   } fx_type;

   // raw effect plus 12-bit parameter to dense code
   function automatic fx_type translate(input logic [7:0] eff, input logic [11:0] data);
      fx_type     r;
      logic [11:0] p;
      logic [11:0] q;
      logic [7:0]  lo;
      lo = data[7:0];
      p = data;
      r.effect = FX_NONE;
      case (eff)
         8'h01: r.effect = FX_PORTA_UP;
         8'h02: r.effect = FX_PORTA_DOWN;
         8'h03: r.effect = FX_TONE_PORTA;
         8'h04: r.effect = FX_VIBRATO;
         8'h05: r.effect = FX_ARPEGGIO;
         8'h07: r.effect = (data < 12'h020) ? FX_SPEED : FX_TEMPO;
         8'h08: begin
            r.effect = FX_PAN;
            p = {data[10:0], 1'b0};
         end
         8'h0B: r.effect = FX_JUMP;
         8'h0C: r.effect = FX_GLOBAL_VOL;
         8'h0D: begin
            r.effect = FX_BREAK;
            p = {8'd0, data[3:0]} + {8'd0, data[7:4]} * 12'd10;
         end
         8'h0E: begin
            r.effect = FX_EXTENDED;
            case (lo & 8'hF0)
               8'h00: r.effect = FX_NONE;
               8'h10: begin
                  if (data[3:0] != 4'd0) begin
                     p = data | 12'h0F0;
                     r.effect = FX_PAN_SLIDE;
                  end else r.effect = FX_NONE;
               end
               8'h20: begin
                  if (data[3:0] != 4'd0) begin
                     p = {data[7:0], 4'hF};
                     r.effect = FX_PAN_SLIDE;
                  end else r.effect = FX_NONE;
               end
               8'h30: p = {8'd0, data[3:0]} | 12'h010;
               8'h40: p = {8'd0, data[3:0]} | 12'h030;
               8'h60: p = {8'd0, data[3:0]} | 12'h0B0;
               8'h70: p = {8'd0, data[3:0]} | 12'h040;
               8'h90: begin
                  r.effect = FX_RETRIG;
                  p = {8'd0, data[3:0]};
               end
               8'hA0: begin
                  p = {4'd0, data[3:0], 4'd0};
                  r.effect = FX_GVOL_SLIDE;
               end
               8'hB0: begin
                  p = {8'd0, data[3:0]};
                  r.effect = FX_GVOL_SLIDE;
               end
               8'hF0: p = {8'd0, data[11:8]} | 12'h0A0;
               default: ;
            endcase
         end
         8'h0F: r.effect = FX_SPEED;
         8'h10: begin
            if ((lo & 8'hF0) != 8'hE0) begin
               r.effect = FX_VOL_SLIDE;
               if ((lo & 8'hF0) == 8'hF0) p = {data[7:0], 4'hF};
               else begin
                  q = data >> 2;
                  if (q > 12'h00F) q = 12'h00F;
                  p = q << 4;
               end
            end
         end
         8'h20: begin
            if ((lo & 8'hF0) != 8'hE0) begin
               r.effect = FX_VOL_SLIDE;
               if ((lo & 8'hF0) != 8'hF0) begin
                  q = data >> 2;
                  if (q > 12'h00F) q = 12'h00F;
                  p = q;
               end
            end
         end
         8'h30: r.effect = FX_RETRIG;
         8'h40: r.effect = FX_TREMOLO;
         8'h50: r.effect = FX_TREMOR;
         8'hEF: begin
            if (p > 12'h0FF) p = 12'h0FF;
            r.effect = FX_OFFSET;
         end
         default: ;
      endcase
      r.param = p[7:0];
      r.valid = (r.effect != FX_NONE);
      return r;
   endfunction

   function automatic cell_type build_cell(input logic [39:0] g, input logic [7:0] p2_in);
      cell_type   c;
      fx_type     f;
      logic [7:0] vol;
      logic [7:0] c1;
      logic [7:0] c2;
      logic [11:0] p1;
      logic [7:0] p2;
      logic [8:0] vsum;
      vol = g[23:16];
      c1 = {4'd0, g[27:24]};
      c2 = {g[31:28], 4'd0};
      p1 = {4'd0, g[39:32]};
      p2 = p2_in;
      c = '0;
      c.note = g[7:0];
      c.instrument = g[15:8];
      if (c1 == 8'h0E && g[39:36] == 4'hF && c2 == 8'd0) begin
         p1 = {g[35:32], p2};
         c1 = 8'hEF;
         p2 = 8'd0;
      end
      if (vol != 8'd0) begin
         vsum = {1'b0, vol} + 9'd1;
         c.has_volume = 1'b1;
         c.volume = vsum[8:2];
      end
      f = translate(c1, p1);
      if (f.valid) begin
         c.effect = f.effect;
         c.effect_param = f.param;
      end
      if (c.effect != FX_SPEED && c.effect != FX_TEMPO && c.effect != FX_BREAK) begin
         f = translate(c2, {4'd0, p2});
         if (f.valid) begin
            c.effect = f.effect;
            c.effect_param = f.param;
         end
      end
      return c;
   endfunction

endpackage

>>> design/ptu_if.sv
// valid/ready stream interfaces for requests, decoded cells and the row count register
// depends on nothing
`timescale 1ns / 1ps
interface ptu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] track_byte;
   logic       new_track;
   modport source (output valid, track_byte, new_track, input ready);
   modport sink (input valid, track_byte, new_track, output ready);
endinterface

interface ptu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] row_index;
   logic [7:0] note;
   logic [7:0] instrument;
   logic       has_volume;
   logic [6:0] volume;
   logic [4:0] effect;
   logic [7:0] effect_param;
   logic       last_of_run;
   modport source (output valid, row_index, note, instrument, has_volume, volume, effect,
                   effect_param, last_of_run, input ready);
   modport sink (input valid, row_index, note, instrument, has_volume, volume, effect,
                 effect_param, last_of_run, output ready);
endinterface

interface ptu_csr_if;
   logic       valid;
   logic       ready;
   logic [8:0] row_count;
   modport source (output valid, row_count, input ready);
   modport sink (input valid, row_count, output ready);
endinterface

>>> design/ptu_row_mem.sv
// row store: registered synchronous read, one write port, epoch-tagged clearing
// depends on ptu_pkg
`timescale 1ns / 1ps
module ptu_row_mem #(
   parameter int MaxRows = ptu_pkg::MaxRowsDefault,
   localparam int Aw = (MaxRows > 1) ? $clog2(MaxRows) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic                sweep_req,
   input  logic                rd_en,
   input  logic [Aw-1:0]       rd_addr,
   output ptu_pkg::cell_type   rd_data,
   input  logic                wr_en,
   input  logic [Aw-1:0]       wr_addr,
   input  ptu_pkg::cell_type   wr_data,
   output logic                busy,
   output logic                last_epoch
);
   import ptu_pkg::*;

   localparam logic [Aw:0] SweepLast = (Aw + 1)'(MaxRows - 1);

   // each entry carries the epoch it was written in; older epochs read as empty
   cell_type    mem [MaxRows];
   logic [7:0]  tag [MaxRows];
   logic [7:0]  epoch_ff, epoch_in;
   cell_type    cell_ff;
   logic [7:0]  tag_ff;
   logic        sweep_ff, sweep_in;
   logic [Aw:0] sweep_ptr_ff, sweep_ptr_in;

   // tags are swept to 0 after reset and before the epoch would wrap;
   // live epochs run from 1 to 255, so a swept tag never matches
   always_comb begin
      epoch_in = epoch_ff;
      sweep_in = sweep_ff;
      sweep_ptr_in = sweep_ptr_ff;
      if (sweep_ff) begin
         sweep_ptr_in = sweep_ptr_ff + 1'b1;
         if (sweep_ptr_ff == SweepLast) begin
            sweep_in = 1'b0;
            epoch_in = 8'd1;
         end
      end else if (sweep_req) begin
         sweep_in = 1'b1;
         sweep_ptr_in = '0;
      end else if (clear) begin
         epoch_in = epoch_ff + 8'd1;
      end
   end

   assign busy = sweep_ff;
   assign last_epoch = (epoch_ff == 8'hFF);

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= 8'd1;
         sweep_ff <= 1'b1;
         sweep_ptr_ff <= '0;
      end else begin
         epoch_ff <= epoch_in;
         sweep_ff <= sweep_in;
         sweep_ptr_ff <= sweep_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         cell_ff <= mem[rd_addr];
      end
   end

   // tag array: written on cell writes and by the clearing sweep, never both
   always_ff @(posedge clock) begin
      if (sweep_ff) begin
         tag[sweep_ptr_ff[Aw-1:0]] <= 8'd0;
      end else if (wr_en) begin
         tag[wr_addr] <= epoch_in;
      end
      if (rd_en) begin
         tag_ff <= tag[rd_addr];
      end
   end

   assign rd_data = (tag_ff == epoch_ff) ? cell_ff : '0;
endmodule

>>> design/pattern_track_unpacker.sv
// Pattern track unpacker: takes one packed track byte per request and returns the
// decoded note cells with their row numbers. Skip headers and gathered bytes are
// done in the cycle their request is taken; a copy header goes through issue, memory
// read and result handshake; a repeat header emits its cells through read, present and
// read of the next row for up to 64 rows while further requests wait, and the receiver
// can stall each cell. The rate is set by the single row store port pair, read in the
// cycle before the write. After reset the row store tags are swept before the first
// request is taken; new_track clears the store by moving to a fresh epoch, and a new
// track that arrives on the last epoch first waits for another sweep.
// depends on ptu_pkg, ptu_if, ptu_row_mem
`timescale 1ns / 1ps
module pattern_track_unpacker #(
   parameter int MAX_ROWS = ptu_pkg::MaxRowsDefault
) (
   input  logic   clock,
   input  logic   reset,
   ptu_req_if.sink   req,
   ptu_rsp_if.source rsp,
   ptu_csr_if.sink   csr
);
   import ptu_pkg::*;

   localparam int Aw = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int Pw = $clog2(MAX_ROWS + 1);
   localparam logic [Pw:0] MaxRowsP = (Pw + 1)'(MAX_ROWS);

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_REPEAT, ST_OUT} state_type;

   state_type   state_ff;
   logic [8:0]  row_count_ff;
   logic [Pw:0] row_pos_ff;
   logic [5:0]  pend_ff;
   logic [39:0] gath_ff;
   logic [1:0]  kind_ff;
   logic [6:0]  left_ff;
   logic        copy_ff;
   cell_type    out_cell_ff;
   logic [7:0]  out_row_ff;
   logic        out_last_ff;

   logic        clear;
   logic        sweep_req;
   logic        mem_busy;
   logic        mem_last_epoch;
   logic        rd_en;
   logic [Aw-1:0] rd_addr;
   cell_type    rd_data;
   logic        wr_en;
   logic [Aw-1:0] wr_addr;
   cell_type    wr_data;
   logic [Pw:0] lim;
   logic [Pw:0] pos_now;
   logic [5:0]  pend_now;
   logic [39:0] gath_now;
   logic [5:0]  xx;
   logic [2:0]  k;
   logic [5:0]  pend_rem;
   logic [Pw+1:0] skip_sum;

   assign csr.ready = 1'b1;
   // a new track on the last epoch waits for the tag sweep
   assign req.ready = (state_ff == ST_IDLE) && !mem_busy
                      && !(req.new_track && mem_last_epoch) && !(rsp.valid && !rsp.ready);
   assign sweep_req = (state_ff == ST_IDLE) && !mem_busy && req.valid && req.new_track
                      && mem_last_epoch;
   assign xx = req.track_byte[7:2];
   assign clear = req.valid && req.ready && req.new_track;

   always_comb begin
      if (row_count_ff > 9'(MAX_ROWS)) lim = MaxRowsP;
      else lim = (Pw + 1)'(row_count_ff);
   end

   assign pos_now = clear ? '0 : row_pos_ff;
   assign pend_now = clear ? '0 : pend_ff;
   assign gath_now = clear ? '0 : gath_ff;

   always_comb begin
      k = 3'd5;
      for (int i = 4; i >= 0; i--) begin
         if (pend_now[i]) k = 3'(i);
      end
      pend_rem = pend_now & ~(6'd1 << k);
   end

   assign skip_sum = {1'b0, pos_now} + (Pw + 2)'(xx) + 1'b1;

   // read address: previous row for repeat, source row for copy
   always_comb begin
      rd_en = 1'b0;
      rd_addr = pos_now[Aw-1:0];
      if (state_ff == ST_IDLE && req.valid && req.ready && pend_now == 6'd0
          && pos_now < lim) begin
         rd_en = 1'b1;
         if (header_type'(req.track_byte[1:0]) == HDR_REPEAT) begin
            rd_addr = (pos_now == '0) ? '0 : Aw'(pos_now - 1'b1);
         end else if ((Pw + 1)'(xx) < pos_now) begin
            rd_addr = Aw'(xx);
         end
      end else if (state_ff == ST_REPEAT) begin
         rd_en = 1'b1;
         rd_addr = Aw'(row_pos_ff - 1'b1);
      end
   end

   ptu_row_mem #(.MaxRows(MAX_ROWS)) u_mem (
      .clock, .reset, .clear, .sweep_req, .rd_en, .rd_addr, .rd_data,
      .wr_en, .wr_addr, .wr_data, .busy(mem_busy), .last_epoch(mem_last_epoch)
   );

   // write port: gathered cell at issue, copied/repeated cell after the read
   always_comb begin
      wr_en = 1'b0;
      wr_addr = row_pos_ff[Aw-1:0];
      wr_data = rd_data;
      if (state_ff == ST_READ) begin
         wr_en = (kind_ff == HDR_COPY) ? copy_ff : (row_pos_ff != '0);
      end
      if (state_ff == ST_IDLE && req.valid && req.ready) begin
         if (pend_now != 6'd0) begin
            if (pend_rem == 6'd0 && pos_now < lim) begin
               wr_en = 1'b1;
               wr_addr = pos_now[Aw-1:0];
               wr_data = build_cell(gath_now | (40'(req.track_byte) << (8 * k)),
                                    (k == 3'd5) ? req.track_byte : 8'd0);
            end
         end else if (pos_now < lim && header_type'(req.track_byte[1:0]) == HDR_GATHER
                      && xx == 6'd0) begin
            wr_en = 1'b1;
            wr_addr = pos_now[Aw-1:0];
            wr_data = build_cell(40'd0, 8'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_count_ff <= RowCountReset;
         row_pos_ff <= '0;
         pend_ff <= '0;
         gath_ff <= '0;
         rsp.valid <= 1'b0;
      end else begin
         if (csr.valid) row_count_ff <= csr.row_count;
         if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req.valid && req.ready) begin
                  row_pos_ff <= pos_now;
                  pend_ff <= pend_now;
                  gath_ff <= gath_now;
                  if (pend_now != 6'd0) begin
                     pend_ff <= pend_rem;
                     if (k != 3'd5) gath_ff <= gath_now | (40'(req.track_byte) << (8 * k));
                     if (pend_rem == 6'd0 && pos_now < lim) begin
                        out_cell_ff <= wr_data;
                        out_row_ff <= 8'(pos_now);
                        out_last_ff <= 1'b1;
                        rsp.valid <= 1'b1;
                        row_pos_ff <= pos_now + 1'b1;
                     end
                  end else if (pos_now < lim) begin
                     kind_ff <= req.track_byte[1:0];
                     left_ff <= {1'b0, xx} + 7'd1;
                     copy_ff <= (Pw + 1)'(xx) < pos_now;
                     case (header_type'(req.track_byte[1:0]))
                        HDR_SKIP: begin
                           row_pos_ff <= (skip_sum > {1'b0, MaxRowsP}) ? MaxRowsP
                                         : skip_sum[Pw:0];
                        end
                        HDR_GATHER: begin
                           gath_ff <= '0;
                           pend_ff <= xx;
                           if (xx == 6'd0) begin
                              out_cell_ff <= wr_data;
                              out_row_ff <= 8'(pos_now);
                              out_last_ff <= 1'b1;
                              rsp.valid <= 1'b1;
                              row_pos_ff <= pos_now + 1'b1;
                           end
                        end
                        default: state_ff <= ST_READ;
                     endcase
                  end
               end
            end
            ST_READ: begin
               // emit cell read last cycle (or the unchanged current row)
               out_row_ff <= 8'(row_pos_ff);
               out_cell_ff <= rd_data;
               state_ff <= ST_OUT;
               rsp.valid <= 1'b1;
               row_pos_ff <= row_pos_ff + 1'b1;
               if (kind_ff == HDR_COPY || left_ff == 7'd1 || row_pos_ff + 1'b1 >= lim) begin
                  out_last_ff <= 1'b1;
                  left_ff <= 7'd0;
               end else begin
                  out_last_ff <= 1'b0;
                  left_ff <= left_ff - 7'd1;
               end
            end
            ST_OUT: begin
               if (!rsp.valid || rsp.ready) begin
                  state_ff <= (left_ff == 7'd0) ? ST_IDLE : ST_REPEAT;
               end
            end
            ST_REPEAT: state_ff <= ST_READ;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // ST_READ for copy with no valid source keeps the current row: read it instead
   assign rsp.row_index = out_row_ff;
   assign rsp.note = out_cell_ff.note;
   assign rsp.instrument = out_cell_ff.instrument;
   assign rsp.has_volume = out_cell_ff.has_volume;
   assign rsp.volume = out_cell_ff.volume;
   assign rsp.effect = out_cell_ff.effect;
   assign rsp.effect_param = out_cell_ff.effect_param;
   assign rsp.last_of_run = out_last_ff;
endmodule
